// ===== design/rpt_pkg.sv =====
// Shared types, field widths and codes for the replication progress tracker.
// No dependencies; imported by every module of the block except rpt_ram.
package rpt_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;
    localparam int IDX_W   = 64;
    localparam int FUNC_W  = 4;
    localparam int MODE_W  = 2;
    localparam int LIMIT_W = 9;
    localparam int COUNT_W = 9;
    localparam int IN_W    = 128;
    localparam int OUT_W   = 208;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic [FUNC_W-1:0] FN_PROBE     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_REPLICATE = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SNAPSHOT  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ACK       = 4'd3;
    localparam logic [FUNC_W-1:0] FN_OPTIMIST  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REJECT    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_PAUSE     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_RESUME    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SNAPFAIL  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_ADD       = 4'd9;
    localparam logic [FUNC_W-1:0] FN_FREETO    = 4'd10;
    localparam logic [FUNC_W-1:0] FN_FREEFIRST = 4'd11;

    localparam logic [MODE_W-1:0] MODE_PROBE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPLICATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SNAPSHOT  = 2'd2;

    // register indexes
    localparam logic [0:0] REG_WINDOW_LIMIT = 1'b0;

    // result bit positions in m_tdata
    localparam int OB_ACC     = 0;
    localparam int OB_ERR     = 1;
    localparam int OB_MODE    = 2;
    localparam int OB_PAUSED  = 196;
    localparam int OB_ABORT   = 197;

    typedef enum logic {
        ALU_INC,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic               wr;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    function automatic logic [OUT_W-1:0] pack_result(
        input logic               acc,
        input logic               err,
        input logic [MODE_W-1:0]  mode,
        input logic [IDX_W-1:0]   next_idx,
        input logic [IDX_W-1:0]   match_idx,
        input logic [IDX_W-1:0]   pending_idx,
        input logic               paused,
        input logic               abort,
        input logic [COUNT_W-1:0] count
    );
        return {1'b0, count, abort, paused, pending_idx, match_idx, next_idx, mode, err, acc};
    endfunction

endpackage

// ===== design/rpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rpt_alu.sv =====
// Shared 64-bit unit: increment, or subtract giving less-than and equal flags.
// Depends on rpt_pkg.
module rpt_alu
    import rpt_pkg::*;
(
    input  alu_op_t          op,
    input  logic [IDX_W-1:0] a,
    input  logic [IDX_W-1:0] b,
    output logic [IDX_W-1:0] res,
    output logic             lt,
    output logic             eq
);

    logic [IDX_W:0] sum;
    logic [IDX_W-1:0] b_in;
    logic             cin;

    always_comb begin
        if (op == ALU_SUB) begin
            b_in = ~b;
        end else begin
            b_in = '0;
        end
        cin = 1'b1;
        sum = {1'b0, a} + {1'b0, b_in} + {{IDX_W{1'b0}}, cin};
        res = sum[IDX_W-1:0];
        lt  = (op == ALU_SUB) && !sum[IDX_W];
        eq  = (sum[IDX_W-1:0] == '0);
    end

endmodule

// ===== design/rpt_regs.sv =====
// APB configuration register: window_limit, clamped to the usable window size.
// Depends on rpt_pkg.
module rpt_regs
    import rpt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[APB_AW-1] == REG_WINDOW_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (wr_hit) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[APB_AW-1] == REG_WINDOW_LIMIT) begin
            prdata = {{(APB_DW-LIMIT_W){1'b0}}, limit_reg};
        end else begin
            prdata = '0;
        end
        cfg.wr = wr_hit;
        if (limit_reg == '0) begin
            cfg.limit = {{(LIMIT_W-1){1'b0}}, 1'b1};
        end else if (32'(limit_reg) > WINDOW_DEPTH) begin
            cfg.limit = LIMIT_W'(WINDOW_DEPTH);
        end else begin
            cfg.limit = limit_reg;
        end
    end

endmodule

// ===== design/rpt_ctrl.sv =====
// Event sequencer: progress state, in-flight ring pointers and result register.
// Depends on rpt_pkg, rpt_alu and rpt_ram.
module rpt_ctrl
    import rpt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] in_func,
    input  logic [IDX_W-1:0]  in_index,
    input  logic [IDX_W-1:0]  in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_data
);

    localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int PW = LIMIT_W + 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_FF_RD    = 3'd2;
    localparam logic [2:0] ST_FF_LD    = 3'd3;
    localparam logic [2:0] ST_FREE_RD  = 3'd4;
    localparam logic [2:0] ST_FREE_CMP = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [IDX_W-1:0]   t0_reg, t0_next;
    logic [IDX_W-1:0]   t1_reg, t1_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [IDX_W-1:0]   nidx_reg, nidx_next;
    logic [IDX_W-1:0]   match_reg, match_next;
    logic [IDX_W-1:0]   pend_reg, pend_next;
    logic               paused_reg, paused_next;
    logic [HW-1:0]      head_reg, head_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic               acc_reg, acc_next;
    logic               err_reg, err_next;
    logic               oval_reg, oval_next;
    logic [OUT_W-1:0]   odata_reg, odata_next;

    alu_op_t            alu_op;
    logic [IDX_W-1:0]   alu_a, alu_b, alu_res;
    logic               alu_lt, alu_eq;

    logic               ram_we;
    logic [HW-1:0]      ram_waddr;
    logic [IDX_W-1:0]   ram_rdata;

    logic               full;
    logic               paused_out;
    logic [PW-1:0]      pos_sum, pos_wrap, head_inc;
    logic [IDX_W-1:0]   rej_val;

    rpt_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .lt  (alu_lt),
        .eq  (alu_eq)
    );

    rpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (n_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

    assign full = (fill_reg >= cfg.limit);

    always_comb begin
        pos_sum = PW'(head_reg) + PW'(fill_reg);
        if (pos_sum >= PW'(cfg.limit)) begin
            pos_wrap = pos_sum - PW'(cfg.limit);
        end else begin
            pos_wrap = pos_sum;
        end
        head_inc = PW'(head_reg) + {{(PW-1){1'b0}}, 1'b1};
        if (head_inc >= PW'(cfg.limit)) begin
            head_inc = '0;
        end
        ram_waddr = HW'(pos_wrap);
    end

    always_comb begin
        case (mode_reg)
            MODE_PROBE:     paused_out = paused_reg;
            MODE_REPLICATE: paused_out = full;
            default:        paused_out = 1'b1;
        endcase
        if (n_reg == '0 || t1_reg == '0) begin
            rej_val = {{(IDX_W-1){1'b0}}, 1'b1};
        end else if (alu_lt) begin
            rej_val = n_reg;
        end else begin
            rej_val = t1_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        func_next   = func_reg;
        n_next      = n_reg;
        last_next   = last_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        mode_next   = mode_reg;
        nidx_next   = nidx_reg;
        match_next  = match_reg;
        pend_next   = pend_reg;
        paused_next = paused_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        oval_next   = oval_reg && !out_ready;
        odata_next  = odata_reg;
        ram_we      = 1'b0;
        alu_op      = ALU_INC;
        alu_a       = '0;
        alu_b       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    func_next = in_func;
                    n_next    = in_index;
                    last_next = in_last;
                    t0_next   = in_index;
                    step_next = 2'd0;
                    acc_next  = 1'b0;
                    err_next  = 1'b0;
                    if (in_func == FN_FREETO) begin
                        state_next = (fill_reg == '0) ? ST_DONE : ST_FREE_RD;
                    end else if (in_func == FN_FREEFIRST) begin
                        state_next = (fill_reg == '0) ? ST_DONE : ST_FF_RD;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                step_next  = step_reg + 2'd1;
                state_next = ST_DONE;
                case (func_reg)
                    FN_PROBE: begin
                        case (step_reg)
                            2'd0: begin
                                alu_a      = match_reg;
                                t0_next    = alu_res;
                                state_next = ST_EXEC;
                            end
                            2'd1: begin
                                alu_a      = pend_reg;
                                t1_next    = alu_res;
                                state_next = ST_EXEC;
                            end
                            default: begin
                                alu_op      = ALU_SUB;
                                alu_a       = t0_reg;
                                alu_b       = t1_reg;
                                nidx_next   = (mode_reg == MODE_SNAPSHOT && alu_lt) ?
                                              t1_reg : t0_reg;
                                mode_next   = MODE_PROBE;
                                paused_next = 1'b0;
                                pend_next   = '0;
                                head_next   = '0;
                                fill_next   = '0;
                            end
                        endcase
                    end
                    FN_REPLICATE: begin
                        alu_a       = match_reg;
                        nidx_next   = alu_res;
                        mode_next   = MODE_REPLICATE;
                        paused_next = 1'b0;
                        pend_next   = '0;
                        head_next   = '0;
                        fill_next   = '0;
                    end
                    FN_SNAPSHOT: begin
                        mode_next   = MODE_SNAPSHOT;
                        paused_next = 1'b0;
                        pend_next   = n_reg;
                        head_next   = '0;
                        fill_next   = '0;
                    end
                    FN_ACK: begin
                        case (step_reg)
                            2'd0: begin
                                alu_op     = ALU_SUB;
                                alu_a      = match_reg;
                                alu_b      = n_reg;
                                state_next = ST_EXEC;
                                if (alu_lt) begin
                                    match_next  = n_reg;
                                    acc_next    = 1'b1;
                                    paused_next = 1'b0;
                                end
                            end
                            2'd1: begin
                                alu_a      = n_reg;
                                t0_next    = alu_res;
                                state_next = ST_EXEC;
                            end
                            default: begin
                                alu_op = ALU_SUB;
                                alu_a  = nidx_reg;
                                alu_b  = t0_reg;
                                if (alu_lt) begin
                                    nidx_next = t0_reg;
                                end
                            end
                        endcase
                    end
                    FN_OPTIMIST: begin
                        alu_a     = n_reg;
                        nidx_next = alu_res;
                    end
                    FN_REJECT: begin
                        if (mode_reg == MODE_REPLICATE) begin
                            if (step_reg == 2'd0) begin
                                alu_op = ALU_SUB;
                                alu_a  = match_reg;
                                alu_b  = n_reg;
                                if (alu_lt) begin
                                    acc_next   = 1'b1;
                                    state_next = ST_EXEC;
                                end
                            end else begin
                                alu_a     = match_reg;
                                nidx_next = alu_res;
                            end
                        end else begin
                            case (step_reg)
                                2'd0: begin
                                    alu_a      = n_reg;
                                    t0_next    = alu_res;
                                    state_next = ST_EXEC;
                                end
                                2'd1: begin
                                    alu_op = ALU_SUB;
                                    alu_a  = nidx_reg;
                                    alu_b  = t0_reg;
                                    if (alu_eq) begin
                                        state_next = ST_EXEC;
                                    end
                                end
                                2'd2: begin
                                    alu_a      = last_reg;
                                    t1_next    = alu_res;
                                    state_next = ST_EXEC;
                                end
                                default: begin
                                    alu_op      = ALU_SUB;
                                    alu_a       = n_reg;
                                    alu_b       = t1_reg;
                                    nidx_next   = rej_val;
                                    paused_next = 1'b0;
                                    acc_next    = 1'b1;
                                end
                            endcase
                        end
                    end
                    FN_PAUSE:    paused_next = 1'b1;
                    FN_RESUME:   paused_next = 1'b0;
                    FN_SNAPFAIL: pend_next   = '0;
                    FN_ADD: begin
                        if (full) begin
                            err_next = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FF_RD: begin
                state_next = ST_FF_LD;
            end
            ST_FF_LD: begin
                t0_next    = ram_rdata;
                state_next = ST_FREE_RD;
            end
            ST_FREE_RD: begin
                state_next = ST_FREE_CMP;
            end
            ST_FREE_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = t0_reg;
                alu_b  = ram_rdata;
                if (alu_lt) begin
                    state_next = ST_DONE;
                end else begin
                    fill_next = fill_reg - {{(COUNT_W-1){1'b0}}, 1'b1};
                    if (fill_reg == {{(COUNT_W-1){1'b0}}, 1'b1}) begin
                        head_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        head_next  = HW'(head_inc);
                        state_next = ST_FREE_RD;
                    end
                end
            end
            ST_DONE: begin
                // match >= pending for the abort flag
                alu_op = ALU_SUB;
                alu_a  = match_reg;
                alu_b  = pend_reg;
                if (!oval_reg || out_ready) begin
                    oval_next  = 1'b1;
                    odata_next = pack_result(acc_reg, err_reg, mode_reg, nidx_reg,
                                             match_reg, pend_reg, paused_out,
                                             (mode_reg == MODE_SNAPSHOT) && !alu_lt,
                                             fill_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.wr) begin
            head_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= 2'd0;
            mode_reg   <= MODE_PROBE;
            nidx_reg   <= '0;
            match_reg  <= '0;
            pend_reg   <= '0;
            paused_reg <= 1'b0;
            head_reg   <= '0;
            fill_reg   <= '0;
            acc_reg    <= 1'b0;
            err_reg    <= 1'b0;
            oval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mode_reg   <= mode_next;
            nidx_reg   <= nidx_next;
            match_reg  <= match_next;
            pend_reg   <= pend_next;
            paused_reg <= paused_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        n_reg     <= n_next;
        last_reg  <= last_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        odata_reg <= odata_next;
    end

endmodule

// ===== design/replication_progress_tracker.sv =====
// Replication progress tracker for one follower: top level.
// Depends on rpt_pkg, rpt_regs and rpt_ctrl.
//
// One event per input transaction, one status result per event. The block takes
// one event at a time: s_tready is high only while the sequencer is idle, and an
// event is accepted, then runs its steps through the shared 64-bit add/compare
// unit, then loads the result register. Free events walk the in-flight ring,
// examining each entry with a RAM read and then a compare in the shared unit;
// freefirst first fetches the head entry from the RAM. A free on an empty window
// goes straight to the result. Each entry is freed once. A finished result waits
// in the output register while the next event is accepted. No clearing pass
// after reset.
module replication_progress_tracker
    import rpt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // log_index[63:0], hint_last[127:64]
    input  logic [FUNC_W-1:0] s_tuser,   // func[3:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // accepted[0], window_error[1], mode[3:2],
                                         // next_index[67:4], match_index[131:68],
                                         // pending_index[195:132], is_paused[196],
                                         // snapshot_abort[197], inflight_count[206:198]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    assign pready = 1'b1;

    rpt_regs #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rpt_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_index  (s_tdata[IDX_W-1:0]),
        .in_last   (s_tdata[2*IDX_W-1:IDX_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== design/rpt_checker.sv =====
// Port-level checks for the replication progress tracker, bound to the top level.
// Depends on rpt_pkg.
module rpt_checker
    import rpt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one event in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted transaction");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OB_ACC] && m_tdata[OB_ERR]))
        else $error("accepted and window_error both set");

    a_snap_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OB_MODE+1:OB_MODE] == MODE_SNAPSHOT) |-> m_tdata[OB_PAUSED])
        else $error("snapshot mode reported not paused");

    a_abort_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OB_ABORT] |-> (m_tdata[OB_MODE+1:OB_MODE] == MODE_SNAPSHOT))
        else $error("snapshot_abort outside snapshot mode");

endmodule

bind replication_progress_tracker rpt_checker u_rpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for replication_progress_tracker: directed event table, then
// randomized phases under several window limits, scored against an internal tracker model.
// Depends on rpt_pkg and the replication_progress_tracker RTL.
`timescale 1ns / 100ps

module tb;
    import rpt_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_SHOWN   = 10;
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd12;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;
    localparam logic [APB_AW-1:0] LIMIT_ADDR   = APB_AW'(4 * REG_WINDOW_LIMIT);
    localparam int NUM_PHASES  = 9;
    localparam int SLOT_W      = $clog2(WINDOW_DEPTH_DEF);

    // same bit order as m_tdata[206:0]
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               abort;
        logic               paused;
        logic [IDX_W-1:0]   pending;
        logic [IDX_W-1:0]   match_idx;
        logic [IDX_W-1:0]   next_idx;
        logic [MODE_W-1:0]  mode;
        logic               err;
        logic               acc;
    } status_t;

    typedef struct {
        bit                 is_cfg;
        logic [LIMIT_W-1:0] cfg_val;
        logic [FUNC_W-1:0]  fn;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   hint;
        bit                 typed;
        status_t            want;
    } event_row_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [FUNC_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    replication_progress_tracker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // tracker model state
    logic [LIMIT_W-1:0] trk_limit = LIMIT_RESET;
    logic [MODE_W-1:0]  trk_mode  = MODE_PROBE;
    logic [IDX_W-1:0]   trk_next  = '0;
    logic [IDX_W-1:0]   trk_match = '0;
    logic               trk_paused = 1'b0;
    logic [IDX_W-1:0]   trk_pending = '0;
    logic [IDX_W-1:0]   trk_store [WINDOW_DEPTH_DEF];
    int                 trk_head = 0;
    int                 trk_fill = 0;

    status_t    status_q [$];
    event_row_t dir_rows [$];
    int         errors = 0;
    int         results_seen = 0;
    int         cycles = 0;
    int         gap_pct = 30;
    int         stall_pct = 30;
    bit         wide = 1'b0;
    logic [IDX_W-1:0] add_cursor = '0;

    function automatic int eff_limit();
        int lim;
        lim = int'(trk_limit);
        if (lim < 1) lim = 1;
        if (lim > WINDOW_DEPTH_DEF) lim = WINDOW_DEPTH_DEF;
        return lim;
    endfunction

    function automatic void enter_mode(logic [MODE_W-1:0] m);
        trk_paused  = 1'b0;
        trk_pending = '0;
        trk_mode    = m;
        trk_head    = 0;
        trk_fill    = 0;
    endfunction

    function automatic void free_window(logic [IDX_W-1:0] bound);
        int lim, pos, freed;
        lim   = eff_limit();
        pos   = trk_head;
        freed = 0;
        while (freed < trk_fill && !(bound < trk_store[pos[SLOT_W-1:0]])) begin
            pos++;
            if (pos >= lim) pos -= lim;
            freed++;
        end
        trk_fill -= freed;
        trk_head  = (trk_fill == 0) ? 0 : pos;
    endfunction

    function automatic status_t track_event(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] n,
                                            logic [IDX_W-1:0] last);
        status_t s;
        logic [IDX_W-1:0] p1, m1, n1, l1, v;
        logic was_snap;
        int lim, pos;
        s   = '0;
        lim = eff_limit();
        n1  = n + 64'd1;
        case (fn)
            FN_PROBE: begin
                was_snap = (trk_mode == MODE_SNAPSHOT);
                p1 = trk_pending + 64'd1;
                m1 = trk_match + 64'd1;
                enter_mode(MODE_PROBE);
                trk_next = (was_snap && p1 > m1) ? p1 : m1;
            end
            FN_REPLICATE: begin
                enter_mode(MODE_REPLICATE);
                trk_next = trk_match + 64'd1;
            end
            FN_SNAPSHOT: begin
                enter_mode(MODE_SNAPSHOT);
                trk_pending = n;
            end
            FN_ACK: begin
                if (trk_match < n) begin
                    trk_match  = n;
                    trk_paused = 1'b0;
                    s.acc      = 1'b1;
                end
                if (trk_next < n1) trk_next = n1;
            end
            FN_OPTIMIST: trk_next = n1;
            FN_REJECT: begin
                v = trk_next - 64'd1;
                if (trk_mode == MODE_REPLICATE) begin
                    if (n > trk_match) begin
                        trk_next = trk_match + 64'd1;
                        s.acc    = 1'b1;
                    end
                end else if (v == n) begin
                    l1 = last + 64'd1;
                    v  = (n < l1) ? n : l1;
                    if (v == '0) v = 64'd1;
                    trk_next   = v;
                    trk_paused = 1'b0;
                    s.acc      = 1'b1;
                end
            end
            FN_PAUSE:    trk_paused = 1'b1;
            FN_RESUME:   trk_paused = 1'b0;
            FN_SNAPFAIL: trk_pending = '0;
            FN_ADD: begin
                if (trk_fill >= lim) begin
                    s.err = 1'b1;
                end else begin
                    pos = trk_head + trk_fill;
                    if (pos >= lim) pos -= lim;
                    trk_store[pos[SLOT_W-1:0]] = n;
                    trk_fill++;
                end
            end
            FN_FREETO:    if (trk_fill != 0) free_window(n);
            FN_FREEFIRST: if (trk_fill != 0) free_window(trk_store[trk_head[SLOT_W-1:0]]);
            default: ;
        endcase
        s.mode      = trk_mode;
        s.next_idx  = trk_next;
        s.match_idx = trk_match;
        s.pending   = trk_pending;
        if (trk_mode == MODE_PROBE) s.paused = trk_paused;
        else if (trk_mode == MODE_REPLICATE) s.paused = (trk_fill >= lim);
        else s.paused = 1'b1;
        s.abort = (trk_mode == MODE_SNAPSHOT) && (trk_match >= trk_pending);
        s.count = COUNT_W'(trk_fill);
        return s;
    endfunction

    function automatic void note_mismatch(string what, logic [IDX_W-1:0] want,
                                          logic [IDX_W-1:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("MISMATCH %s: expected %h, got %h (t=%0t)", what, want, got, $realtime);
    endfunction

    function automatic void check_status(logic [OUT_W-1:0] word);
        status_t got, want;
        got = status_t'(word[$bits(status_t)-1:0]);
        if (status_q.size() == 0) begin
            note_mismatch("result with nothing expected", '0, word[IDX_W-1:0]);
            return;
        end
        want = status_q.pop_front();
        if (got.acc !== want.acc)
            note_mismatch("accepted", 64'(want.acc), 64'(got.acc));
        if (got.err !== want.err)
            note_mismatch("window_error", 64'(want.err), 64'(got.err));
        if (got.mode !== want.mode)
            note_mismatch("mode", 64'(want.mode), 64'(got.mode));
        if (got.next_idx !== want.next_idx)
            note_mismatch("next_index", want.next_idx, got.next_idx);
        if (got.match_idx !== want.match_idx)
            note_mismatch("match_index", want.match_idx, got.match_idx);
        if (got.pending !== want.pending)
            note_mismatch("pending_index", want.pending, got.pending);
        if (got.paused !== want.paused)
            note_mismatch("is_paused", 64'(want.paused), 64'(got.paused));
        if (got.abort !== want.abort)
            note_mismatch("snapshot_abort", 64'(want.abort), 64'(got.abort));
        if (got.count !== want.count)
            note_mismatch("inflight_count", 64'(want.count), 64'(got.count));
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
    endfunction

    function automatic logic [IDX_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result side: random back-pressure plus one long hold-off
    initial begin
        int stall_left;
        bit long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_status(m_tdata);
                results_seen++;
            end
            if (!long_hold_done && results_seen >= 80) begin
                long_hold_done = 1'b1;
                stall_left     = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct) stall_left = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                              input logic [IDX_W-1:0] hint, input bit typed,
                              input status_t want);
        int gap;
        status_t pred;
        gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {hint, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = track_event(fn, idx, hint);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic read_window_limit(input logic [LIMIT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== APB_DW'(want))
            note_mismatch("window_limit readback", 64'(want), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_window_limit(input logic [LIMIT_W-1:0] val);
        logic [APB_DW-1:0] word;
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        word = $urandom;
        word[LIMIT_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        trk_limit = val;
        trk_head  = 0;
        trk_fill  = 0;
        read_window_limit(val);
    endtask

    function automatic logic [FUNC_W-1:0] FN_LIMIT_SAFE_UNUSED();
        return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    endfunction

    task automatic random_event(output logic [FUNC_W-1:0] fn, output logic [IDX_W-1:0] idx,
                                output logic [IDX_W-1:0] hint);
        int r, d, slot;
        logic [IDX_W-1:0] e;
        r    = $urandom_range(0, 99);
        d    = $urandom_range(0, 11);
        hint = rand64();
        idx  = rand64();
        if (r < 4) begin
            fn = FN_PROBE;
        end else if (r < 8) begin
            fn = FN_REPLICATE;
        end else if (r < 11) begin
            fn = FN_SNAPSHOT;
            if (d < 10)
                idx = (d < 4 && trk_match >= 64'd20) ? trk_match - 64'(d * 5)
                                                      : trk_match + 64'(d * 2);
        end else if (r < 26) begin
            fn = FN_ACK;
            if (!(wide && d == 0))
                idx = (d < 3 && trk_match >= 64'd3) ? trk_match - 64'(d + 1)
                                                     : trk_match + 64'(d % 9);
        end else if (r < 30) begin
            fn = FN_OPTIMIST;
            if (d != 0) idx = trk_next + 64'(d % 4);
        end else if (r < 42) begin
            fn = FN_REJECT;
            if (trk_mode == MODE_REPLICATE)
                idx = (d < 4 && trk_match >= 64'd3) ? trk_match - 64'(d % 3)
                                                     : trk_match + 64'(d % 6);
            else if (d < 9)
                idx = trk_next - 64'd1;
            else if (d < 11)
                idx = trk_next + 64'(d);
            case ($urandom_range(0, 3))
                0: hint = idx - 64'($urandom_range(0, 4));
                1: hint = idx + 64'($urandom_range(0, 4));
                2: hint = '1;
                default: ;
            endcase
        end else if (r < 46) begin
            fn = FN_PAUSE;
        end else if (r < 49) begin
            fn = FN_RESUME;
        end else if (r < 52) begin
            fn = FN_SNAPFAIL;
        end else if (r < 72) begin
            fn = FN_ADD;
            add_cursor = add_cursor + 64'($urandom_range(0, 3));
            if (d != 0 || !wide) idx = (d == 11) ? 64'($urandom_range(0, 65535)) : add_cursor;
        end else if (r < 84) begin
            fn = FN_FREETO;
            if (trk_fill > 0 && d < 10) begin
                slot = (trk_head + int'($urandom_range(0, trk_fill - 1))) % eff_limit();
                e    = trk_store[slot[SLOT_W-1:0]];
                idx  = (d < 3) ? e - 64'd1 : e;
            end else if (d == 10) begin
                idx = '1;
            end
        end else if (r < 94) begin
            fn = FN_FREEFIRST;
        end else if (r < 96) begin
            fn = FN_LIMIT_SAFE_UNUSED();
        end else begin
            fn = FN_ACK;
            idx = trk_next + 64'(d);
        end
        if (wide && $urandom_range(0, 3) == 0) idx = rand64();
    endtask

    function automatic event_row_t ev(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                      logic [IDX_W-1:0] hint);
        event_row_t row;
        row = '{default: '0};
        row.fn   = fn;
        row.idx  = idx;
        row.hint = hint;
        return row;
    endfunction

    initial begin
        event_row_t row;
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0] idx, hint;
        int phase_limit [NUM_PHASES];
        int phase_len [NUM_PHASES];
        int lim, burst;

        phase_limit = '{256, 1, 0, 511, 3, 17, 300, 2, 0};
        phase_len   = '{300, 150, 150, 320, 150, 150, 260, 150, 250};

        row = ev(FN_RESUME, '0, '0);
        row.typed = 1'b1;
        row.want  = '0;
        dir_rows.push_back(row);
        dir_rows.push_back(ev(FN_OPTIMIST, 64'd5, '0));
        dir_rows.push_back(ev(FN_REJECT, 64'd5, 64'd2));
        dir_rows.push_back(ev(FN_REJECT, 64'd2, '1));
        dir_rows.push_back(ev(FN_REJECT, 64'd7, 64'd0));
        dir_rows.push_back(ev(FN_PAUSE, '1, '1));
        dir_rows.push_back(ev(FN_ACK, 64'd10, '0));
        dir_rows.push_back(ev(FN_SNAPSHOT, 64'd4, '0));
        dir_rows.push_back(ev(FN_PROBE, '0, '0));
        dir_rows.push_back(ev(FN_SNAPSHOT, '1, '0));
        dir_rows.push_back(ev(FN_PROBE, '0, '0));
        dir_rows.push_back(ev(FN_REPLICATE, '0, '0));
        dir_rows.push_back(ev(FN_REJECT, 64'd10, '0));
        dir_rows.push_back(ev(FN_REJECT, 64'd20, '0));
        dir_rows.push_back(ev(FN_UNUSED_HI, '1, '1));
        dir_rows.push_back(ev(FN_SNAPFAIL, '0, '0));
        row = ev(FN_ADD, '0, '0);
        row.is_cfg  = 1'b1;
        row.cfg_val = 9'd2;
        dir_rows.push_back(row);
        dir_rows.push_back(ev(FN_ADD, 64'd30, '0));
        dir_rows.push_back(ev(FN_ADD, 64'd31, '0));
        dir_rows.push_back(ev(FN_ADD, 64'd32, '0));
        dir_rows.push_back(ev(FN_FREETO, 64'd30, '0));
        dir_rows.push_back(ev(FN_ADD, 64'd29, '0));
        dir_rows.push_back(ev(FN_FREETO, 64'd30, '0));
        dir_rows.push_back(ev(FN_FREEFIRST, '0, '0));
        dir_rows.push_back(ev(FN_FREEFIRST, '0, '0));
        dir_rows.push_back(ev(FN_FREETO, '0, '0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_window_limit(LIMIT_RESET);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                set_window_limit(dir_rows[i].cfg_val);
            else
                send_event(dir_rows[i].fn, dir_rows[i].idx, dir_rows[i].hint,
                           dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                phase_limit[p] = $urandom_range(4, 40);
                wide = 1'b1;
            end
            set_window_limit(LIMIT_W'(phase_limit[p]));
            case (p % 3)
                0: begin gap_pct = 30; stall_pct = 30; end
                1: begin gap_pct = 70; stall_pct = 10; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            lim   = eff_limit();
            burst = (lim + 2 < phase_len[p]) ? lim + 2 : phase_len[p];
            for (int k = 0; k < phase_len[p]; k++) begin
                if (k < burst) begin
                    add_cursor = add_cursor + 64'($urandom_range(0, 3));
                    send_event(FN_ADD, add_cursor, rand64(), 1'b0, '0);
                end else begin
                    random_event(fn, idx, hint);
                    send_event(fn, idx, hint, 1'b0, '0);
                end
            end
        end
        if (!wide) wide = 1'b1;
        send_event(FN_ACK, '1, '1, 1'b0, '0);

        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
